@@ rtl/core/ibmw_pkg.sv @@
`default_nettype none

package ibmw_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_RETURN = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Result kinds carried in the output tuser.
  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_RANGE  = 2'd2;
  localparam logic [1:0] KIND_BUSY   = 2'd3;

  // Slot layout of the inode block map.
  localparam int unsigned DIRECT_SLOTS = 12;
  localparam int unsigned NUM_SLOTS    = 15;
  localparam logic [3:0]  SLOT_SINGLE  = 4'd12;
  localparam logic [3:0]  SLOT_DOUBLE  = 4'd13;
  localparam logic [3:0]  SLOT_TRIPLE  = 4'd14;

  // Block size limits, as log2 of bytes.
  localparam logic [4:0] BS_LOG2_MIN   = 5'd10;
  localparam logic [4:0] BS_LOG2_MAX   = 5'd16;
  localparam logic [4:0] BS_LOG2_RESET = 5'd12;

  localparam int unsigned IDX_W  = 14;
  localparam int unsigned ADDR_W = 48;

  typedef logic [31:0] block_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0] idx_t;

endpackage

`default_nettype wire

@@ rtl/core/indirect_block_map_walker_core.sv @@
`default_nettype none

// Inode block map walker. Load the 15 pointer slots with op 0, look up a
// logical block with op 1, and feed each fetched pointer word back with op 2.
// Direct blocks answer at once; indirect blocks produce one byte-address read
// request per tree level until the physical block comes back. A lookup made
// while a read is outstanding is answered as busy, and a return with no walk
// pending is dropped. The block takes one item per clock unless the input
// stalls; an item passes an input register and then a result register, which
// presents its result on the output. The input stalls only while the result
// register holds an item that the output side has not taken and another item
// waits behind it, or while reset is high.
module indirect_block_map_walker_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [4:0]   cfg_wdata,      // block_size_log2
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [3:0] slot_index, [35:4] slot_pointer, [67:36] logical_block,
  // [99:68] read_word, [103:100] zero
  input  wire logic [103:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,   // [1:0] op
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [79:0]       m_axis_tdata,   // [31:0] physical_block, [79:32] read_address
  output logic [1:0]        m_axis_tuser    // [1:0] kind
);

  // Configuration and walk state.
  logic [4:0]          block_size_log2;
  ibmw_pkg::block_t    slots [ibmw_pkg::NUM_SLOTS];
  logic [1:0]          levels_left;
  logic [31:0]         remaining_offset;
  logic                walk_busy;

  // Input register.
  logic                in_valid;
  logic [1:0]          in_op;
  logic [3:0]          in_slot_index;
  ibmw_pkg::block_t    in_slot_pointer;
  ibmw_pkg::block_t    in_logical_block;
  ibmw_pkg::block_t    in_read_word;

  // Result register.
  logic                out_valid;
  logic [1:0]          out_kind;
  ibmw_pkg::block_t    out_pb;
  ibmw_pkg::addr_t     out_addr;

  logic advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || advance);

  // Geometry derived from the block size.
  logic [4:0]  bs;
  logic [3:0]  sh;
  logic [4:0]  sh2;
  logic [5:0]  sh3;
  logic [13:0] idx_mask;
  logic [43:0] lim_single;
  logic [43:0] lim_double;
  logic [43:0] lim_triple;

  always_comb begin
    if (block_size_log2 < ibmw_pkg::BS_LOG2_MIN) begin
      bs = ibmw_pkg::BS_LOG2_MIN;
    end else if (block_size_log2 > ibmw_pkg::BS_LOG2_MAX) begin
      bs = ibmw_pkg::BS_LOG2_MAX;
    end else begin
      bs = block_size_log2;
    end
    sh       = 4'(bs - 5'd2);
    sh2      = {sh, 1'b0};
    sh3      = 6'({2'b0, sh}) + 6'({1'b0, sh2});
    idx_mask = ~(14'h3fff << sh);
    // Upper bounds (exclusive) of the single, double and triple ranges.
    lim_single = 44'(ibmw_pkg::DIRECT_SLOTS) + (44'd1 << sh);
    lim_double = lim_single + (44'd1 << sh2);
    lim_triple = lim_double + (44'd1 << sh3);
  end

  // Item processing.
  logic                res_valid;
  logic [1:0]          res_kind;
  ibmw_pkg::block_t    res_pb;
  ibmw_pkg::addr_t     res_addr;
  logic [1:0]          levels_left_next;
  logic [31:0]         remaining_offset_next;
  logic                walk_busy_next;
  logic                req_en;
  ibmw_pkg::block_t    req_blk;
  ibmw_pkg::idx_t      req_idx;
  logic [43:0]         lb_ext;
  logic [31:0]         off_single;
  logic [31:0]         off_double;
  logic [31:0]         off_triple;
  logic [1:0]          k;
  logic [31:0]         rem_shifted;

  always_comb begin
    lb_ext     = {12'b0, in_logical_block};
    off_single = in_logical_block - 32'(ibmw_pkg::DIRECT_SLOTS);
    off_double = in_logical_block - lim_single[31:0];
    off_triple = in_logical_block - lim_double[31:0];
    k          = (levels_left > 2'd2) ? 2'd2 : levels_left;
    rem_shifted = (k == 2'd2) ? (remaining_offset >> sh) : remaining_offset;

    res_valid             = 1'b0;
    res_kind              = ibmw_pkg::KIND_ANSWER;
    res_pb                = '0;
    res_addr              = '0;
    levels_left_next      = levels_left;
    remaining_offset_next = remaining_offset;
    walk_busy_next        = walk_busy;
    req_en                = 1'b0;
    req_blk               = '0;
    req_idx               = '0;

    unique case (in_op)
      ibmw_pkg::OP_LOOKUP: begin
        res_valid = 1'b1;
        if (walk_busy) begin
          res_kind = ibmw_pkg::KIND_BUSY;
        end else if (lb_ext < 44'(ibmw_pkg::DIRECT_SLOTS)) begin
          res_pb = slots[in_logical_block[3:0]];
        end else if (lb_ext < lim_single) begin
          levels_left_next      = 2'd0;
          remaining_offset_next = '0;
          req_en  = 1'b1;
          req_blk = slots[ibmw_pkg::SLOT_SINGLE];
          req_idx = off_single[13:0] & idx_mask;
        end else if (lb_ext < lim_double) begin
          levels_left_next      = 2'd1;
          remaining_offset_next = off_double;
          req_en  = 1'b1;
          req_blk = slots[ibmw_pkg::SLOT_DOUBLE];
          req_idx = 14'(off_double >> sh) & idx_mask;
        end else if (lb_ext < lim_triple) begin
          levels_left_next      = 2'd2;
          remaining_offset_next = off_triple;
          req_en  = 1'b1;
          req_blk = slots[ibmw_pkg::SLOT_TRIPLE];
          req_idx = 14'(off_triple >> sh2) & idx_mask;
        end else begin
          res_kind = ibmw_pkg::KIND_RANGE;
        end
      end
      ibmw_pkg::OP_RETURN: begin
        if (walk_busy) begin
          res_valid = 1'b1;
          if (k == 2'd0) begin
            walk_busy_next        = 1'b0;
            remaining_offset_next = '0;
            res_pb                = in_read_word;
          end else begin
            levels_left_next = k - 2'd1;
            req_en  = 1'b1;
            req_blk = in_read_word;
            req_idx = rem_shifted[13:0] & idx_mask;
          end
        end
      end
      default: begin
      end
    endcase

    // A zero index block is a hole: answer block zero and end the walk.
    if (req_en) begin
      if (req_blk == '0) begin
        walk_busy_next        = 1'b0;
        levels_left_next      = 2'd0;
        remaining_offset_next = '0;
      end else begin
        walk_busy_next = 1'b1;
        res_kind       = ibmw_pkg::KIND_READ;
        res_addr       = (ibmw_pkg::addr_t'(req_blk) << bs)
                       | ibmw_pkg::addr_t'({req_idx, 2'b00});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      block_size_log2  <= ibmw_pkg::BS_LOG2_RESET;
      levels_left      <= 2'd0;
      remaining_offset <= '0;
      walk_busy        <= 1'b0;
      for (int i = 0; i < ibmw_pkg::NUM_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        block_size_log2 <= cfg_wdata;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid        <= res_valid;
        levels_left      <= levels_left_next;
        remaining_offset <= remaining_offset_next;
        walk_busy        <= walk_busy_next;
        if (in_op == ibmw_pkg::OP_LOAD && in_slot_index != 4'hf) begin
          slots[in_slot_index] <= in_slot_pointer;
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op            <= s_axis_tuser;
      in_slot_index    <= s_axis_tdata[3:0];
      in_slot_pointer  <= s_axis_tdata[35:4];
      in_logical_block <= s_axis_tdata[67:36];
      in_read_word     <= s_axis_tdata[99:68];
    end
    if (advance) begin
      out_kind <= res_kind;
      out_pb   <= res_pb;
      out_addr <= res_addr;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {out_addr, out_pb};

endmodule

`default_nettype wire

@@ tb/indirect_block_map_walker_core_tb.sv @@
`timescale 1ns / 1ps

module indirect_block_map_walker_core_tb;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned PHASE_ITEMS = 60;
  localparam logic [63:0] LB_LIMIT = 64'h1_0000_0000;

  typedef struct packed {
    logic [1:0]       kind;
    ibmw_pkg::block_t pb;
    ibmw_pkg::addr_t  addr;
  } map_result_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_TRICKLE} rx_mode_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [4:0]   cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = ibmw_pkg::OP_NOP;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  indirect_block_map_walker_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow copy of the block map state and the block size register.
  ibmw_pkg::block_t map_slots [ibmw_pkg::NUM_SLOTS] = '{default: '0};
  logic [1:0]       walk_levels = '0;
  ibmw_pkg::block_t walk_offset = '0;
  bit               walk_pending = 1'b0;
  logic [4:0]       blk_log2 = ibmw_pkg::BS_LOG2_RESET;

  map_result_t results_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  logic        long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("indirect_block_map_walker_core test failed");
    $finish;
  end

  function automatic int unsigned eff_log2();
    if (blk_log2 < ibmw_pkg::BS_LOG2_MIN) return ibmw_pkg::BS_LOG2_MIN;
    if (blk_log2 > ibmw_pkg::BS_LOG2_MAX) return ibmw_pkg::BS_LOG2_MAX;
    return blk_log2;
  endfunction

  // Either requests entry idx of index block blk or, for a zero block, ends
  // the walk with a hole.
  task automatic start_read(input ibmw_pkg::block_t blk, input logic [63:0] idx,
                            output map_result_t res);
    logic [63:0] byte_addr;
    res = '{kind: ibmw_pkg::KIND_ANSWER, pb: '0, addr: '0};
    if (blk == '0) begin
      walk_pending = 1'b0;
      walk_levels = '0;
      walk_offset = '0;
    end else begin
      walk_pending = 1'b1;
      byte_addr = ({32'd0, blk} << eff_log2()) + (idx << 2);
      res.kind = ibmw_pkg::KIND_READ;
      res.addr = byte_addr[ibmw_pkg::ADDR_W-1:0];
    end
  endtask

  task automatic translate_item(input logic [1:0] op, input logic [3:0] si,
                                input ibmw_pkg::block_t ptr,
                                input ibmw_pkg::block_t lb_in,
                                input ibmw_pkg::block_t word, output bit has,
                                output map_result_t res);
    int unsigned s;
    int unsigned k;
    logic [63:0] p;
    logic [63:0] mask;
    logic [63:0] lb;
    s = eff_log2() - 2;
    p = 64'd1 << s;
    mask = p - 1;
    lb = {32'd0, lb_in};
    has = 1'b1;
    res = '{kind: ibmw_pkg::KIND_ANSWER, pb: '0, addr: '0};
    case (op)
      ibmw_pkg::OP_LOAD: begin
        has = 1'b0;
        if (si < ibmw_pkg::NUM_SLOTS) map_slots[si] = ptr;
      end
      ibmw_pkg::OP_LOOKUP: begin
        if (walk_pending) begin
          res.kind = ibmw_pkg::KIND_BUSY;
        end else if (lb < ibmw_pkg::DIRECT_SLOTS) begin
          res.pb = map_slots[lb[3:0]];
        end else begin
          lb = lb - ibmw_pkg::DIRECT_SLOTS;
          if (lb < p) begin
            walk_levels = 2'd0;
            walk_offset = '0;
            start_read(map_slots[ibmw_pkg::SLOT_SINGLE], lb, res);
          end else begin
            lb = lb - p;
            if (lb < (p << s)) begin
              walk_levels = 2'd1;
              walk_offset = lb[31:0];
              start_read(map_slots[ibmw_pkg::SLOT_DOUBLE], (lb >> s) & mask, res);
            end else begin
              lb = lb - (p << s);
              if (lb < (p << (2 * s))) begin
                walk_levels = 2'd2;
                walk_offset = lb[31:0];
                start_read(map_slots[ibmw_pkg::SLOT_TRIPLE],
                           (lb >> (2 * s)) & mask, res);
              end else begin
                res.kind = ibmw_pkg::KIND_RANGE;
              end
            end
          end
        end
      end
      ibmw_pkg::OP_RETURN: begin
        if (!walk_pending) begin
          has = 1'b0;
        end else if (walk_levels == 2'd0) begin
          walk_pending = 1'b0;
          walk_offset = '0;
          res.pb = word;
        end else begin
          k = (walk_levels > 2'd2) ? 2 : walk_levels;
          walk_levels = 2'(k - 1);
          start_read(word, ({32'd0, walk_offset} >> (s * (k - 1))) & mask, res);
        end
      end
      default: has = 1'b0;
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic [3:0] si,
                           input ibmw_pkg::block_t ptr, input ibmw_pkg::block_t lb,
                           input ibmw_pkg::block_t word);
    int unsigned gap;
    bit has;
    map_result_t res;
    if (!no_gaps && burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap = 0;
        burst_left = 40;
      end else begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 20);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'd0, word, lb, ptr, si};
    do @(posedge clk); while (!s_axis_tready);
    translate_item(op, si, ptr, lb, word, has, res);
    if (has) results_due.push_back(res);
    items_sent++;
  endtask

  task automatic load_slot(input logic [3:0] si, input ibmw_pkg::block_t ptr);
    send_item(ibmw_pkg::OP_LOAD, si, ptr, $urandom, $urandom);
  endtask

  task automatic look_up(input ibmw_pkg::block_t lb);
    send_item(ibmw_pkg::OP_LOOKUP, 4'($urandom), $urandom, lb, $urandom);
  endtask

  task automatic return_word(input ibmw_pkg::block_t word);
    send_item(ibmw_pkg::OP_RETURN, 4'($urandom), $urandom, $urandom, word);
  endtask

  // Waits until every expected result is in and the pipeline has drained.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [4:0] value);
    settle_block();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    blk_log2 = value;
    cfg_we <= 1'b0;
  endtask

  function automatic ibmw_pkg::block_t rand_word();
    if ($urandom_range(0, 11) == 0) return '0;
    return $urandom;
  endfunction

  // Picks a logical block in one region of the map: 0 direct, 1 single,
  // 2 double, 3 triple indirect, 4 past the triple indirect reach.
  function automatic ibmw_pkg::block_t pick_logical(input int region);
    int unsigned s;
    logic [63:0] p;
    logic [63:0] lo;
    logic [63:0] span;
    logic [63:0] offs;
    s = eff_log2() - 2;
    p = 64'd1 << s;
    case (region)
      0: begin lo = 0; span = ibmw_pkg::DIRECT_SLOTS; end
      1: begin lo = ibmw_pkg::DIRECT_SLOTS; span = p; end
      2: begin lo = ibmw_pkg::DIRECT_SLOTS + p; span = p << s; end
      3: begin
        lo = ibmw_pkg::DIRECT_SLOTS + p + (p << s);
        span = p << (2 * s);
      end
      default: begin
        lo = ibmw_pkg::DIRECT_SLOTS + p + (p << s) + (p << (2 * s));
        span = LB_LIMIT - lo;
      end
    endcase
    if (lo >= LB_LIMIT) return 32'hFFFF_FFFF;
    if (lo + span > LB_LIMIT) span = LB_LIMIT - lo;
    case ($urandom_range(0, 7))
      0: offs = 0;
      1: offs = span - 1;
      default: offs = {$urandom, $urandom} % span;
    endcase
    return ibmw_pkg::block_t'(lo + offs);
  endfunction

  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: look_up($urandom);
      1: load_slot(4'($urandom_range(0, 15)), rand_word());
      2: return_word($urandom);
      default: send_item(ibmw_pkg::OP_NOP, 4'($urandom), $urandom, $urandom, $urandom);
    endcase
  endtask

  // A complete lookup: now and then reloads the root slot or a direct slot, then
  // answers every read request until the walk ends, with some interleaved noise.
  task automatic walk_sequence(input int region);
    if (region >= 1 && region <= 3 && $urandom_range(0, 2) == 0)
      load_slot(4'(ibmw_pkg::DIRECT_SLOTS + region - 1), rand_word());
    else if ($urandom_range(0, 3) == 0)
      load_slot(4'($urandom_range(0, ibmw_pkg::DIRECT_SLOTS - 1)), $urandom);
    look_up(pick_logical(region));
    while (walk_pending) begin
      if ($urandom_range(0, 9) == 0) noise_item();
      if (walk_pending) return_word(rand_word());
    end
  endtask

  task automatic test_direct_map();
    load_slot(4'd0, 32'hFFFF_FFFF);
    load_slot(4'd11, 32'h0000_0001);
    load_slot(4'd15, 32'hA5A5_A5A5);
    look_up(32'd0);
    look_up(32'd11);
    look_up(32'd5);
    // Single indirect slot still zero: a hole.
    look_up(32'd12);
    load_slot(ibmw_pkg::SLOT_SINGLE, 32'hFFFF_FFFF);
    look_up(32'd12 + 32'd1023);
    look_up(32'd0);
    send_item(ibmw_pkg::OP_NOP, 4'hF, '1, '1, '1);
    return_word(32'h1234_5678);
    return_word(32'hDEAD_BEEF);
    look_up(32'hFFFF_FFFF);
  endtask

  task automatic test_indirect_walks();
    load_slot(ibmw_pkg::SLOT_DOUBLE, 32'd7);
    load_slot(ibmw_pkg::SLOT_TRIPLE, 32'h8000_0000);
    look_up(32'd12 + 32'd1024);
    return_word(32'd9);
    return_word(32'hFFFF_FFFF);
    // Last triple indirect block, with a hole in the first returned word.
    look_up(32'd12 + 32'd1024 + 32'd1048576 + 32'h3FFF_FFFF);
    return_word(32'd0);
    look_up(32'd12 + 32'd1024 + 32'd1048576);
    return_word(32'd3);
    // Block size changes while the walk waits for its second word.
    write_block_size(5'd31);
    return_word(32'd5);
    return_word(32'h0000_0042);
  endtask

  task automatic test_block_sizes();
    logic [4:0] sizes [4] = '{5'd0, 5'd10, 5'd16, 5'd31};
    foreach (sizes[i]) begin
      write_block_size(sizes[i]);
      for (int region = 0; region <= 4; region++) walk_sequence(region);
    end
  endtask

  task automatic test_backpressure();
    long_hold_req <= 1'b1;
    no_gaps = 1'b1;
    repeat (12) look_up($urandom_range(0, ibmw_pkg::DIRECT_SLOTS - 1));
    repeat (4) load_slot(4'($urandom_range(0, 14)), $urandom);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_walks();
    int unsigned start;
    int unsigned phase_start;
    int unsigned pick;
    start = items_sent;
    phase_start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - phase_start >= PHASE_ITEMS) begin
        if ($urandom_range(0, 1) == 0)
          write_block_size(5'($urandom_range(0, 31)));
        else
          write_block_size(5'($urandom_range(ibmw_pkg::BS_LOG2_MIN,
                                             ibmw_pkg::BS_LOG2_MAX)));
        phase_start = items_sent;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        walk_sequence($urandom_range(0, 4));
      end else if (pick < 85) begin
        // Walk may be left unfinished, so that the next lookup finds it still pending.
        look_up(pick_logical($urandom_range(1, 3)));
        if ($urandom_range(0, 1) == 0) return_word(rand_word());
      end else begin
        repeat ($urandom_range(1, 3)) noise_item();
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    map_result_t got;
    map_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tuser, pb: m_axis_tdata[31:0], addr: m_axis_tdata[79:32]};
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d", got.kind));
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.pb !== want.pb)
          report_mismatch($sformatf("physical_block %h, expected %h", got.pb, want.pb));
        if (got.addr !== want.addr)
          report_mismatch($sformatf("read_address %h, expected %h", got.addr, want.addr));
      end
    end
  end

  // Output side: changes its stall pattern now and then, and serves a long
  // hold when one is requested.
  initial begin
    rx_mode_t    rx_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned rx_phase;
    rx_mode = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    rx_phase = 0;
    forever begin
      @(posedge clk);
      rx_phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req <= 1'b0;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (rx_mode)
          RX_ALWAYS:  m_axis_tready <= 1'b1;
          RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
          RX_PATTERN: m_axis_tready <= (rx_phase % 5) < 3;
          default:    m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_direct_map();
    test_indirect_walks();
    test_block_sizes();
    test_backpressure();
    test_random_walks();
    settle_block();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("indirect_block_map_walker_core test passed");
    end else begin
      $display("indirect_block_map_walker_core test failed");
    end
    $finish;
  end

endmodule

@@ indirect_block_map_walker_core.f @@
rtl/core/ibmw_pkg.sv
rtl/core/indirect_block_map_walker_core.sv
tb/indirect_block_map_walker_core_tb.sv
